// File: rtl/shortest_path_search_core_assert.svh
// assertion macros for the shortest path search core
// used by rtl/shortest_path_search_core.sv; needs clk and rst_n in scope
`ifndef SHORTEST_PATH_SEARCH_CORE_ASSERT_SVH
`define SHORTEST_PATH_SEARCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spsc assertion failed");
`define SPSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spsc assertion failed");
`else
`define SPSC_ASSERT_IMP(lbl, ante, cons)
`define SPSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/spsc_pkg.sv
// shared types and codes for the shortest path search core
// no dependencies
`default_nettype none
package spsc_pkg;

  localparam logic [1:0] KIND_NODE   = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_NO_PATH  = 3'd3;
  localparam logic [2:0] ST_Q_OVF    = 3'd4;
  localparam logic [2:0] ST_LOAD_OVF = 3'd5;

  localparam logic [2:0] CFG_MAX_COST  = 3'd0;
  localparam logic [2:0] CFG_ALLOW_CNT = 3'd1;
  localparam logic [2:0] CFG_REL0      = 3'd2;
  localparam logic [2:0] CFG_REL1      = 3'd3;
  localparam logic [2:0] CFG_REL2      = 3'd4;
  localparam logic [2:0] CFG_REL3      = 3'd5;

  localparam logic [31:0] COST_INF = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_FIND_END, S_INIT,
    S_POP0, S_POP1, S_POP2, S_SD_L, S_SD_R, S_SD_CMP, S_SD_FIN,
    S_VIS_RD, S_VIS_CHK, S_LNK, S_EDGE_TOP, S_EDGE_CHK, S_TGT_RD, S_TGT_CHK,
    S_NX_CHK, S_SU_TOP, S_SU_CHK, S_SU_FIN,
    S_WALK_RD, S_WALK_CHK, S_OUT_RD, S_OUT_N, S_OUT_E, S_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] rel;
    logic [31:0] cost;
    logic [2:0]  status;
    logic        last;
  } res_t;

  function automatic res_t fail_res(input logic [2:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/spsc_ram.sv
// simple dual port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none
module spsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/shortest_path_search_core.sv
// shortest path search core: graph load, dijkstra over a binary min-heap, path output
// depends on spsc_pkg, spsc_ram and shortest_path_search_core_assert.svh
// load node, load edge and clear items are taken while busy stays low: one item per cycle
// a search walks the memories one access at a time: an id scan for start and goal, heap
// pops with sift down, an id scan per edge target, pushes with sift up, then the parent
// walk and the path output; results are one-cycle strobes, no receiver stall
// synchronous active-low reset clears the graph counters and loads config defaults
`default_nettype none
module shortest_path_search_core #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_EDGES  = 256,
  parameter int HEAP_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_node_id,
  input  wire logic [63:0] in_target_id,
  input  wire logic [31:0] in_relation,
  input  wire logic signed [15:0] in_weight,
  output logic             out_valid,
  output logic [63:0]      out_path_node_id,
  output logic [31:0]      out_path_relation,
  output logic [31:0]      out_total_cost,
  output logic [2:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // index and counter widths
  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = NW + 1;
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = EW + 1;
  localparam int HW  = $clog2(HEAP_DEPTH);
  localparam int HCW = HW + 1;

  // memory word layouts
  localparam int LNK_W  = 2 * ECW;              // {edge base, edge count}
  localparam int EDGE_W = 64 + 32 + 16;         // {target, relation, weight}
  localparam int ST_W   = 2 + NW + EW + 32;     // {visited, has parent, parent, edge, best}
  localparam int HEAP_W = 32 + NW;              // {cost, node}
  localparam int ST_PE  = 32;
  localparam int ST_PN  = 32 + EW;
  localparam int ST_HP  = 32 + EW + NW;
  localparam int ST_VIS = ST_W - 1;

  spsc_pkg::state_t state_r, state_nxt;

  // graph bookkeeping
  logic [NCW-1:0] node_total_r, node_total_nxt;
  logic [ECW-1:0] edge_total_r, edge_total_nxt;
  logic           ovf_r, ovf_nxt;
  logic [ECW-1:0] last_base_r, last_base_nxt;
  logic [ECW-1:0] last_cnt_r, last_cnt_nxt;

  // configuration
  logic [31:0] max_cost_r;
  logic [2:0]  allow_cnt_r;
  logic [31:0] allow_r [0:3];

  // search working registers
  logic [63:0]     start_id_r, start_id_nxt;
  logic [63:0]     goal_id_r, goal_id_nxt;
  logic [NW-1:0]   s_r, s_nxt, g_r, g_nxt;
  logic            s_fnd_r, s_fnd_nxt, g_fnd_r, g_fnd_nxt;
  logic [NCW-1:0]  idx_r, idx_nxt;
  logic [HCW-1:0]  cap_r, cap_nxt;
  logic [HCW-1:0]  hcnt_r, hcnt_nxt;
  logic [31:0]     cc_r, cc_nxt;
  logic [NW-1:0]   cn_r, cn_nxt;
  logic [HEAP_W-1:0] last_ent_r, last_ent_nxt;
  logic [HEAP_W-1:0] lch_r, lch_nxt;
  logic [HW-1:0]   hi_r, hi_nxt;
  logic            rv_r, rv_nxt;
  logic [ECW-1:0]  e_r, e_nxt;
  logic [ECW-1:0]  ecnt_r, ecnt_nxt;
  logic [EW-1:0]   cur_e_r, cur_e_nxt;
  logic [63:0]     tgt_r, tgt_nxt;
  logic [31:0]     sum_r, sum_nxt;
  logic [NW-1:0]   nx_r, nx_nxt;
  logic [NCW-1:0]  len_r, len_nxt;
  logic [NW-1:0]   p_r, p_nxt;
  logic [NW-1:0]   cur_r, cur_nxt;
  logic [31:0]     tot_r, tot_nxt;
  logic [63:0]     ident_r, ident_nxt;
  logic            has_rel_r, has_rel_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  spsc_pkg::res_t   res_r, res_nxt;

  // memory ports
  logic              nid_we;
  logic [NW-1:0]     nid_wa, nid_ra;
  logic [63:0]       nid_wd, nid_rd;
  logic              lnk_we;
  logic [NW-1:0]     lnk_wa, lnk_ra;
  logic [LNK_W-1:0]  lnk_wd, lnk_rd;
  logic              edg_we;
  logic [EW-1:0]     edg_wa, edg_ra;
  logic [EDGE_W-1:0] edg_wd, edg_rd;
  logic              st_we;
  logic [NW-1:0]     st_wa, st_ra;
  logic [ST_W-1:0]   st_wd, st_rd;
  logic              hp_we;
  logic [HW-1:0]     hp_wa, hp_ra;
  logic [HEAP_W-1:0] hp_wd, hp_rd;
  logic              ch_we;
  logic [NW-1:0]     ch_wa, ch_ra;
  logic [NW-1:0]     ch_wd, ch_rd;

  spsc_ram #(.WIDTH(64), .DEPTH(MAX_NODES), .AW(NW)) u_node_id (
    .clk(clk), .we(nid_we), .waddr(nid_wa), .wdata(nid_wd), .raddr(nid_ra), .rdata(nid_rd));
  spsc_ram #(.WIDTH(LNK_W), .DEPTH(MAX_NODES), .AW(NW)) u_node_lnk (
    .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  spsc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EW)) u_edge (
    .clk(clk), .we(edg_we), .waddr(edg_wa), .wdata(edg_wd), .raddr(edg_ra), .rdata(edg_rd));
  spsc_ram #(.WIDTH(ST_W), .DEPTH(MAX_NODES), .AW(NW)) u_node_st (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  spsc_ram #(.WIDTH(HEAP_W), .DEPTH(HEAP_DEPTH), .AW(HW)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));
  spsc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NW)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));

  assign busy      = (state_r != spsc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_path_node_id  = res_r.id;
  assign out_path_relation = res_r.rel;
  assign out_total_cost    = res_r.cost;
  assign out_status        = res_r.status;
  assign out_last          = res_r.last;

  // relation whitelist, a count above four counts as four
  logic [31:0] e_rel;
  logic [15:0] e_w;
  logic [63:0] e_tgt;
  logic [2:0]  allow_n;
  logic        rel_ok;
  assign e_w   = edg_rd[15:0];
  assign e_rel = edg_rd[47:16];
  assign e_tgt = edg_rd[111:48];
  assign allow_n = (allow_cnt_r > 3'd4) ? 3'd4 : allow_cnt_r;

  always_comb begin
    rel_ok = (allow_n == 3'd0);
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < allow_n) && (allow_r[i] == e_rel)) begin
        rel_ok = 1'b1;
      end
    end
  end

  // saturating relax sum
  logic [32:0] raw_sum;
  logic [31:0] sat_sum;
  assign raw_sum = {1'b0, cc_r} + {17'd0, e_w};
  assign sat_sum = raw_sum[32] ? spsc_pkg::COST_INF : raw_sum[31:0];

  // heap child and parent indices
  logic [HW+1:0] l_idx, r_idx;
  logic [HW-1:0] up_idx;
  logic [HW-1:0] cnt_dec;
  logic [NCW:0]  twice_nodes;
  logic [31:0]   pc;
  logic [HW-1:0] pick;
  logic          pick_moved;
  logic [HEAP_W-1:0] pick_ent;
  assign l_idx  = {1'b0, hi_r, 1'b1};
  assign r_idx  = {1'b0, hi_r, 1'b0} + (HW+2)'(2);
  assign up_idx = (hi_r - HW'(1)) >> 1;
  assign cnt_dec = HW'(hcnt_r - HCW'(1));
  assign twice_nodes = {node_total_r, 1'b0};

  // sift down choice: left wins ties, a child moves up only when strictly smaller
  always_comb begin
    pc = last_ent_r[HEAP_W-1 -: 32];
    pick = hi_r;
    pick_moved = 1'b0;
    pick_ent = lch_r;
    if (lch_r[HEAP_W-1 -: 32] < pc) begin
      pick = l_idx[HW-1:0];
      pc = lch_r[HEAP_W-1 -: 32];
      pick_moved = 1'b1;
      pick_ent = lch_r;
    end
    if (rv_r && (hp_rd[HEAP_W-1 -: 32] < pc)) begin
      pick = r_idx[HW-1:0];
      pick_moved = 1'b1;
      pick_ent = hp_rd;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    node_total_nxt = node_total_r;
    edge_total_nxt = edge_total_r;
    ovf_nxt        = ovf_r;
    last_base_nxt  = last_base_r;
    last_cnt_nxt   = last_cnt_r;
    start_id_nxt   = start_id_r;
    goal_id_nxt    = goal_id_r;
    s_nxt = s_r;  g_nxt = g_r;
    s_fnd_nxt = s_fnd_r;  g_fnd_nxt = g_fnd_r;
    idx_nxt  = idx_r;
    cap_nxt  = cap_r;
    hcnt_nxt = hcnt_r;
    cc_nxt = cc_r;  cn_nxt = cn_r;
    last_ent_nxt = last_ent_r;
    lch_nxt = lch_r;
    hi_nxt  = hi_r;
    rv_nxt  = rv_r;
    e_nxt = e_r;  ecnt_nxt = ecnt_r;
    cur_e_nxt = cur_e_r;
    tgt_nxt = tgt_r;
    sum_nxt = sum_r;
    nx_nxt  = nx_r;
    len_nxt = len_r;
    p_nxt   = p_r;
    cur_nxt = cur_r;
    tot_nxt = tot_r;
    ident_nxt = ident_r;
    has_rel_nxt = has_rel_r;
    out_valid_nxt = 1'b0;
    res_nxt = res_r;

    nid_we = 1'b0; nid_wa = node_total_r[NW-1:0]; nid_wd = in_node_id; nid_ra = idx_r[NW-1:0];
    lnk_we = 1'b0; lnk_wa = node_total_r[NW-1:0]; lnk_wd = {edge_total_r, ECW'(0)};
    lnk_ra = cn_r;
    edg_we = 1'b0; edg_wa = edge_total_r[EW-1:0];
    edg_wd = {in_target_id, in_relation, in_weight}; edg_ra = e_r[EW-1:0];
    st_we = 1'b0; st_wa = cn_r; st_wd = st_rd; st_ra = cn_r;
    hp_we = 1'b0; hp_wa = hi_r; hp_wd = last_ent_r; hp_ra = '0;
    ch_we = 1'b0; ch_wa = len_r[NW-1:0]; ch_wd = cur_r; ch_ra = p_r;

    case (state_r)
      spsc_pkg::S_IDLE: begin
        if (start) begin
          case (in_kind)
            spsc_pkg::KIND_NODE: begin
              if (node_total_r >= NCW'(MAX_NODES)) begin
                ovf_nxt = 1'b1;
              end else begin
                nid_we = 1'b1;
                lnk_we = 1'b1;
                last_base_nxt = edge_total_r;
                last_cnt_nxt = '0;
                node_total_nxt = node_total_r + NCW'(1);
              end
            end
            spsc_pkg::KIND_EDGE: begin
              if (node_total_r != '0) begin
                if (edge_total_r >= ECW'(MAX_EDGES)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  // edge belongs to the most recently loaded node
                  edg_we = 1'b1;
                  lnk_we = 1'b1;
                  lnk_wa = NW'(node_total_r - NCW'(1));
                  lnk_wd = {last_base_r, last_cnt_r + ECW'(1)};
                  last_cnt_nxt = last_cnt_r + ECW'(1);
                  edge_total_nxt = edge_total_r + ECW'(1);
                end
              end
            end
            spsc_pkg::KIND_CLEAR: begin
              node_total_nxt = '0;
              edge_total_nxt = '0;
              ovf_nxt = 1'b0;
              hcnt_nxt = '0;
            end
            default: begin
              // search
              start_id_nxt = in_node_id;
              goal_id_nxt = in_target_id;
              s_fnd_nxt = 1'b0;
              g_fnd_nxt = 1'b0;
              idx_nxt = '0;
              cap_nxt = (twice_nodes > (NCW+1)'(HEAP_DEPTH)) ? HCW'(HEAP_DEPTH)
                                                             : HCW'(twice_nodes);
              if (ovf_r) begin
                out_valid_nxt = 1'b1;
                res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_LOAD_OVF);
              end else if (node_total_r == '0) begin
                out_valid_nxt = 1'b1;
                res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_EMPTY);
              end else begin
                state_nxt = spsc_pkg::S_FIND_RD;
              end
            end
          endcase
        end
      end

      // start and goal take the last matching id
      spsc_pkg::S_FIND_RD: begin
        nid_ra = idx_r[NW-1:0];
        state_nxt = spsc_pkg::S_FIND_CHK;
      end
      spsc_pkg::S_FIND_CHK: begin
        if (nid_rd == start_id_r) begin
          s_nxt = idx_r[NW-1:0];
          s_fnd_nxt = 1'b1;
        end
        if (nid_rd == goal_id_r) begin
          g_nxt = idx_r[NW-1:0];
          g_fnd_nxt = 1'b1;
        end
        if (idx_r == node_total_r - NCW'(1)) begin
          state_nxt = spsc_pkg::S_FIND_END;
        end else begin
          idx_nxt = idx_r + NCW'(1);
          state_nxt = spsc_pkg::S_FIND_RD;
        end
      end
      spsc_pkg::S_FIND_END: begin
        if (!s_fnd_r || !g_fnd_r) begin
          out_valid_nxt = 1'b1;
          res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_UNKNOWN);
          state_nxt = spsc_pkg::S_IDLE;
        end else if (s_r == g_r) begin
          out_valid_nxt = 1'b1;
          res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_FOUND);
          res_nxt.id = start_id_r;
          state_nxt = spsc_pkg::S_IDLE;
        end else begin
          // seed heap with the start node, then sweep the per-node state
          hp_we = 1'b1;
          hp_wa = '0;
          hp_wd = {32'd0, s_r};
          hcnt_nxt = HCW'(1);
          idx_nxt = '0;
          state_nxt = spsc_pkg::S_INIT;
        end
      end
      spsc_pkg::S_INIT: begin
        st_we = 1'b1;
        st_wa = idx_r[NW-1:0];
        st_wd = {2'b00, NW'(0), EW'(0),
                 (idx_r[NW-1:0] == s_r) ? 32'd0 : spsc_pkg::COST_INF};
        idx_nxt = idx_r + NCW'(1);
        if (idx_r == node_total_r - NCW'(1)) begin
          state_nxt = spsc_pkg::S_POP0;
        end
      end

      // pop the minimum
      spsc_pkg::S_POP0: begin
        if (hcnt_r == '0) begin
          out_valid_nxt = 1'b1;
          res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_NO_PATH);
          state_nxt = spsc_pkg::S_IDLE;
        end else begin
          hp_ra = '0;
          state_nxt = spsc_pkg::S_POP1;
        end
      end
      spsc_pkg::S_POP1: begin
        cc_nxt = hp_rd[HEAP_W-1 -: 32];
        cn_nxt = hp_rd[NW-1:0];
        hcnt_nxt = hcnt_r - HCW'(1);
        if (hcnt_r == HCW'(1)) begin
          state_nxt = spsc_pkg::S_VIS_RD;
        end else begin
          hp_ra = cnt_dec;
          state_nxt = spsc_pkg::S_POP2;
        end
      end
      spsc_pkg::S_POP2: begin
        last_ent_nxt = hp_rd;
        hi_nxt = '0;
        state_nxt = spsc_pkg::S_SD_L;
      end
      spsc_pkg::S_SD_L: begin
        if (l_idx >= (HW+2)'(hcnt_r)) begin
          state_nxt = spsc_pkg::S_SD_FIN;
        end else begin
          hp_ra = l_idx[HW-1:0];
          state_nxt = spsc_pkg::S_SD_R;
        end
      end
      spsc_pkg::S_SD_R: begin
        lch_nxt = hp_rd;
        rv_nxt = (r_idx < (HW+2)'(hcnt_r));
        hp_ra = r_idx[HW-1:0];
        state_nxt = spsc_pkg::S_SD_CMP;
      end
      spsc_pkg::S_SD_CMP: begin
        if (!pick_moved) begin
          state_nxt = spsc_pkg::S_SD_FIN;
        end else begin
          hp_we = 1'b1;
          hp_wa = hi_r;
          hp_wd = pick_ent;
          hi_nxt = pick;
          state_nxt = spsc_pkg::S_SD_L;
        end
      end
      spsc_pkg::S_SD_FIN: begin
        hp_we = 1'b1;
        hp_wa = hi_r;
        hp_wd = last_ent_r;
        state_nxt = spsc_pkg::S_VIS_RD;
      end

      // visit the popped node
      spsc_pkg::S_VIS_RD: begin
        st_ra = cn_r;
        state_nxt = spsc_pkg::S_VIS_CHK;
      end
      spsc_pkg::S_VIS_CHK: begin
        if (st_rd[ST_VIS]) begin
          state_nxt = spsc_pkg::S_POP0;
        end else begin
          st_we = 1'b1;
          st_wa = cn_r;
          st_wd = st_rd;
          st_wd[ST_VIS] = 1'b1;
          if (cn_r == g_r) begin
            cur_nxt = g_r;
            len_nxt = '0;
            state_nxt = spsc_pkg::S_WALK_RD;
          end else begin
            lnk_ra = cn_r;
            state_nxt = spsc_pkg::S_LNK;
          end
        end
      end
      spsc_pkg::S_LNK: begin
        e_nxt = lnk_rd[LNK_W-1 -: ECW];
        ecnt_nxt = lnk_rd[ECW-1:0];
        state_nxt = spsc_pkg::S_EDGE_TOP;
      end
      spsc_pkg::S_EDGE_TOP: begin
        if (ecnt_r == '0) begin
          state_nxt = spsc_pkg::S_POP0;
        end else begin
          edg_ra = e_r[EW-1:0];
          cur_e_nxt = e_r[EW-1:0];
          state_nxt = spsc_pkg::S_EDGE_CHK;
        end
      end
      spsc_pkg::S_EDGE_CHK: begin
        e_nxt = e_r + ECW'(1);
        ecnt_nxt = ecnt_r - ECW'(1);
        sum_nxt = sat_sum;
        tgt_nxt = e_tgt;
        idx_nxt = '0;
        // skip non-whitelisted relations, non-positive weights and pruned costs
        if (!rel_ok || e_w[15] || (e_w == 16'd0) || (sat_sum > max_cost_r)) begin
          state_nxt = spsc_pkg::S_EDGE_TOP;
        end else begin
          state_nxt = spsc_pkg::S_TGT_RD;
        end
      end
      // edge target takes the first matching id
      spsc_pkg::S_TGT_RD: begin
        nid_ra = idx_r[NW-1:0];
        state_nxt = spsc_pkg::S_TGT_CHK;
      end
      spsc_pkg::S_TGT_CHK: begin
        if (nid_rd == tgt_r) begin
          nx_nxt = idx_r[NW-1:0];
          st_ra = idx_r[NW-1:0];
          state_nxt = spsc_pkg::S_NX_CHK;
        end else if (idx_r == node_total_r - NCW'(1)) begin
          state_nxt = spsc_pkg::S_EDGE_TOP;
        end else begin
          idx_nxt = idx_r + NCW'(1);
          state_nxt = spsc_pkg::S_TGT_RD;
        end
      end
      spsc_pkg::S_NX_CHK: begin
        if (sum_r < st_rd[31:0]) begin
          st_we = 1'b1;
          st_wa = nx_r;
          st_wd = {st_rd[ST_VIS], 1'b1, cn_r, cur_e_r, sum_r};
          if (hcnt_r >= cap_r) begin
            out_valid_nxt = 1'b1;
            res_nxt = spsc_pkg::fail_res(spsc_pkg::ST_Q_OVF);
            state_nxt = spsc_pkg::S_IDLE;
          end else begin
            hi_nxt = hcnt_r[HW-1:0];
            hcnt_nxt = hcnt_r + HCW'(1);
            state_nxt = spsc_pkg::S_SU_TOP;
          end
        end else begin
          state_nxt = spsc_pkg::S_EDGE_TOP;
        end
      end
      // sift up, stopping at a parent of equal cost
      spsc_pkg::S_SU_TOP: begin
        if (hi_r == '0) begin
          state_nxt = spsc_pkg::S_SU_FIN;
        end else begin
          hp_ra = up_idx;
          state_nxt = spsc_pkg::S_SU_CHK;
        end
      end
      spsc_pkg::S_SU_CHK: begin
        if (hp_rd[HEAP_W-1 -: 32] <= sum_r) begin
          state_nxt = spsc_pkg::S_SU_FIN;
        end else begin
          hp_we = 1'b1;
          hp_wa = hi_r;
          hp_wd = hp_rd;
          hi_nxt = up_idx;
          state_nxt = spsc_pkg::S_SU_TOP;
        end
      end
      spsc_pkg::S_SU_FIN: begin
        hp_we = 1'b1;
        hp_wa = hi_r;
        hp_wd = {sum_r, nx_r};
        state_nxt = spsc_pkg::S_EDGE_TOP;
      end

      // walk parents from the goal into the chain memory
      spsc_pkg::S_WALK_RD: begin
        st_ra = cur_r;
        state_nxt = spsc_pkg::S_WALK_CHK;
      end
      spsc_pkg::S_WALK_CHK: begin
        if (len_r == '0) begin
          tot_nxt = st_rd[31:0];
        end
        ch_we = 1'b1;
        ch_wa = len_r[NW-1:0];
        ch_wd = cur_r;
        len_nxt = len_r + NCW'(1);
        if (!st_rd[ST_HP] || (len_r + NCW'(1) >= node_total_r)) begin
          p_nxt = len_r[NW-1:0];
          state_nxt = spsc_pkg::S_OUT_RD;
        end else begin
          cur_nxt = st_rd[ST_PN +: NW];
          state_nxt = spsc_pkg::S_WALK_RD;
        end
      end
      // play the chain back from start to goal
      spsc_pkg::S_OUT_RD: begin
        ch_ra = p_r;
        state_nxt = spsc_pkg::S_OUT_N;
      end
      spsc_pkg::S_OUT_N: begin
        nid_ra = ch_rd;
        st_ra = ch_rd;
        state_nxt = spsc_pkg::S_OUT_E;
      end
      spsc_pkg::S_OUT_E: begin
        ident_nxt = nid_rd;
        has_rel_nxt = st_rd[ST_HP];
        edg_ra = st_rd[ST_PE +: EW];
        state_nxt = spsc_pkg::S_OUT_EMIT;
      end
      spsc_pkg::S_OUT_EMIT: begin
        out_valid_nxt = 1'b1;
        res_nxt.id = ident_r;
        res_nxt.rel = has_rel_r ? e_rel : 32'd0;
        res_nxt.cost = tot_r;
        res_nxt.status = spsc_pkg::ST_FOUND;
        res_nxt.last = (p_r == '0);
        if (p_r == '0) begin
          state_nxt = spsc_pkg::S_IDLE;
        end else begin
          p_nxt = p_r - NW'(1);
          state_nxt = spsc_pkg::S_OUT_RD;
        end
      end
      default: begin
        state_nxt = spsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spsc_pkg::S_IDLE;
      node_total_r <= '0;
      edge_total_r <= '0;
      ovf_r <= 1'b0;
      hcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      node_total_r <= node_total_nxt;
      edge_total_r <= edge_total_nxt;
      ovf_r <= ovf_nxt;
      hcnt_r <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cost_r <= spsc_pkg::COST_INF;
      allow_cnt_r <= '0;
      for (int i = 0; i < 4; i++) begin
        allow_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spsc_pkg::CFG_MAX_COST:  max_cost_r <= cfg_data;
        spsc_pkg::CFG_ALLOW_CNT: allow_cnt_r <= cfg_data[2:0];
        spsc_pkg::CFG_REL0:      allow_r[0] <= cfg_data;
        spsc_pkg::CFG_REL1:      allow_r[1] <= cfg_data;
        spsc_pkg::CFG_REL2:      allow_r[2] <= cfg_data;
        spsc_pkg::CFG_REL3:      allow_r[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    last_base_r <= last_base_nxt;
    last_cnt_r <= last_cnt_nxt;
    start_id_r <= start_id_nxt;
    goal_id_r <= goal_id_nxt;
    s_r <= s_nxt;
    g_r <= g_nxt;
    s_fnd_r <= s_fnd_nxt;
    g_fnd_r <= g_fnd_nxt;
    idx_r <= idx_nxt;
    cap_r <= cap_nxt;
    cc_r <= cc_nxt;
    cn_r <= cn_nxt;
    last_ent_r <= last_ent_nxt;
    lch_r <= lch_nxt;
    hi_r <= hi_nxt;
    rv_r <= rv_nxt;
    e_r <= e_nxt;
    ecnt_r <= ecnt_nxt;
    cur_e_r <= cur_e_nxt;
    tgt_r <= tgt_nxt;
    sum_r <= sum_nxt;
    nx_r <= nx_nxt;
    len_r <= len_nxt;
    p_r <= p_nxt;
    cur_r <= cur_nxt;
    tot_r <= tot_nxt;
    ident_r <= ident_nxt;
    has_rel_r <= has_rel_nxt;
    res_r <= res_nxt;
  end

  // id scan phase, the heap count still belongs to the previous search
  logic find_phase;
  assign find_phase = (state_r inside {spsc_pkg::S_FIND_RD, spsc_pkg::S_FIND_CHK,
                                       spsc_pkg::S_FIND_END});

`include "shortest_path_search_core_assert.svh"

  // a failed search is always a single, final result
  `SPSC_ASSERT_IMP(a_fail_is_last, out_valid_r && (res_r.status != spsc_pkg::ST_FOUND), res_r.last)
  // the final result of a search leaves the block idle
  `SPSC_ASSERT_IMP(a_last_idle, out_valid_r && res_r.last, !busy)
  // the heap never holds more than its capacity while searching
  `SPSC_ASSERT_IMP(a_heap_cap, busy && !find_phase, hcnt_r <= cap_r)
  // a search item either answers at once or starts working
  `SPSC_ASSERT_NXT(a_search_acts, start && !busy && (in_kind == spsc_pkg::KIND_SEARCH), out_valid_r || busy)

endmodule
`default_nettype wire

// File: test/shortest_path_search_core_tb.sv
// testbench for shortest_path_search_core: graph loads, searches, config and overflow cases
// depends on rtl/spsc_pkg.sv and the core itself; predicts every path result internally
`default_nettype none
module shortest_path_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES_MAX = 64;
  localparam int EDGES_MAX = 256;
  localparam int HEAP_MAX  = 128;
  localparam int unsigned NONE = 32'hFFFF_FFFF;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [63:0] in_node_id = '0;
  logic [63:0] in_target_id = '0;
  logic [31:0] in_relation = '0;
  logic [15:0] in_weight = '0;
  logic out_valid;
  logic [63:0] out_path_node_id;
  logic [31:0] out_path_relation;
  logic [31:0] out_total_cost;
  logic [2:0] out_status;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #1 clk = ~clk;

  shortest_path_search_core DUT (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_node_id, .in_target_id, .in_relation, .in_weight,
    .out_valid, .out_path_node_id, .out_path_relation, .out_total_cost,
    .out_status, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predicted path results, oldest first
  spsc_pkg::res_t path_q[$];
  int errors = 0;
  int items_sent = 0;
  int searches = 0;
  int results_seen = 0;
  int idle_pct = 11;
  int stall_cnt = 0;

  // mirror of the graph and the search state
  logic [63:0] g_ident [NODES_MAX];
  int unsigned g_ebase [NODES_MAX];
  int unsigned g_ecnt [NODES_MAX];
  logic [63:0] e_tgt [EDGES_MAX];
  logic [31:0] e_rel [EDGES_MAX];
  logic [15:0] e_wt [EDGES_MAX];
  int unsigned cost_best [NODES_MAX];
  int unsigned par_node [NODES_MAX];
  int unsigned par_edge [NODES_MAX];
  bit seen [NODES_MAX];
  int unsigned hp_cost [HEAP_MAX];
  int unsigned hp_node [HEAP_MAX];
  int unsigned hp_cnt = 0;
  int unsigned n_nodes = 0;
  int unsigned n_edges = 0;
  bit g_ovf = 1'b0;

  // mirrored registers
  logic [31:0] lim_cost = spsc_pkg::COST_INF;
  logic [2:0] allow_n = '0;
  logic [31:0] allow_rel [4] = '{default: '0};

  function automatic void expect_fail(logic [2:0] st);
    spsc_pkg::res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    path_q.push_back(r);
  endfunction

  // sift up stops at a parent of equal cost
  function automatic bit heap_ins(int unsigned cap, int unsigned c, int unsigned n);
    int unsigned i, up;
    if (hp_cnt >= cap || hp_cnt >= HEAP_MAX) return 1'b0;
    i = hp_cnt;
    hp_cnt++;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (hp_cost[up] <= c) break;
      hp_cost[i] = hp_cost[up];
      hp_node[i] = hp_node[up];
      i = up;
    end
    hp_cost[i] = c;
    hp_node[i] = n;
    return 1'b1;
  endfunction

  // last entry sinks past strictly smaller children, left wins ties
  function automatic void heap_take(output int unsigned c, output int unsigned n);
    int unsigned lc, ln, i, l, r, pick, pc;
    c = hp_cost[0];
    n = hp_node[0];
    hp_cnt--;
    if (hp_cnt == 0) return;
    lc = hp_cost[hp_cnt];
    ln = hp_node[hp_cnt];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      pick = i;
      pc = lc;
      if (l < hp_cnt && hp_cost[l] < pc) begin
        pick = l;
        pc = hp_cost[l];
      end
      if (r < hp_cnt && hp_cost[r] < pc) pick = r;
      if (pick == i) break;
      hp_cost[i] = hp_cost[pick];
      hp_node[i] = hp_node[pick];
      i = pick;
    end
    hp_cost[i] = lc;
    hp_node[i] = ln;
  endfunction

  function automatic bit rel_allowed(logic [31:0] rel);
    int n;
    n = (allow_n > 4) ? 4 : allow_n;
    if (n == 0) return 1'b1;
    for (int i = 0; i < n; i++) if (allow_rel[i] == rel) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_path(logic [63:0] from_id, logic [63:0] to_id);
    int unsigned s, g, cap, cc, cn, e, nx, len, cur;
    longint unsigned sum;
    int unsigned chain [NODES_MAX];
    spsc_pkg::res_t r;
    s = NONE;
    g = NONE;
    if (g_ovf) begin
      expect_fail(spsc_pkg::ST_LOAD_OVF);
      return;
    end
    if (n_nodes == 0) begin
      expect_fail(spsc_pkg::ST_EMPTY);
      return;
    end
    // start and goal take the last matching id
    for (int i = 0; i < n_nodes; i++) begin
      if (g_ident[i] == from_id) s = i;
      if (g_ident[i] == to_id) g = i;
    end
    if (s == NONE || g == NONE) begin
      expect_fail(spsc_pkg::ST_UNKNOWN);
      return;
    end
    if (s == g) begin
      r = '0;
      r.id = g_ident[s];
      r.last = 1'b1;
      path_q.push_back(r);
      return;
    end
    for (int i = 0; i < n_nodes; i++) begin
      cost_best[i] = spsc_pkg::COST_INF;
      par_node[i] = NONE;
      par_edge[i] = 0;
      seen[i] = 1'b0;
    end
    cost_best[s] = 0;
    cap = (2 * n_nodes > HEAP_MAX) ? HEAP_MAX : 2 * n_nodes;
    hp_cnt = 0;
    if (!heap_ins(cap, 0, s)) begin
      expect_fail(spsc_pkg::ST_Q_OVF);
      return;
    end
    while (hp_cnt > 0) begin
      heap_take(cc, cn);
      if (cn >= n_nodes || seen[cn]) continue;
      seen[cn] = 1'b1;
      if (cn == g) break;
      for (int unsigned j = 0; j < g_ecnt[cn]; j++) begin
        e = g_ebase[cn] + j;
        if (e >= EDGES_MAX) break;
        if (!rel_allowed(e_rel[e])) continue;
        if (e_wt[e] == 0 || e_wt[e][15]) continue;
        // edge targets take the first matching id
        nx = NONE;
        for (int unsigned k = 0; k < n_nodes; k++)
          if (g_ident[k] == e_tgt[e]) begin
            nx = k;
            break;
          end
        if (nx == NONE) continue;
        sum = longint'(cc) + e_wt[e];
        if (sum > spsc_pkg::COST_INF) sum = spsc_pkg::COST_INF;
        if (sum > lim_cost) continue;
        if (sum < cost_best[nx]) begin
          cost_best[nx] = 32'(sum);
          par_node[nx] = cn;
          par_edge[nx] = e;
          if (!heap_ins(cap, 32'(sum), nx)) begin
            expect_fail(spsc_pkg::ST_Q_OVF);
            return;
          end
        end
      end
    end
    if (!seen[g] || cost_best[g] > lim_cost) begin
      expect_fail(spsc_pkg::ST_NO_PATH);
      return;
    end
    len = 0;
    cur = g;
    while (cur != NONE && len < n_nodes) begin
      chain[len] = cur;
      len++;
      cur = par_node[cur];
    end
    for (int unsigned i = 0; i < len; i++) begin
      cur = chain[len - 1 - i];
      r = '0;
      r.id = g_ident[cur];
      if (par_node[cur] != NONE) r.rel = e_rel[par_edge[cur] % EDGES_MAX];
      r.cost = cost_best[g];
      r.status = spsc_pkg::ST_FOUND;
      r.last = (i + 1 == len);
      path_q.push_back(r);
    end
  endfunction

  function automatic void predict_item(logic [1:0] k, logic [63:0] nid, logic [63:0] tid,
                                       logic [31:0] rel, logic [15:0] wt);
    case (k)
      spsc_pkg::KIND_NODE: begin
        if (n_nodes >= NODES_MAX) g_ovf = 1'b1;
        else begin
          g_ident[n_nodes] = nid;
          g_ebase[n_nodes] = n_edges;
          g_ecnt[n_nodes] = 0;
          n_nodes++;
        end
      end
      spsc_pkg::KIND_EDGE: begin
        // an edge before any node is dropped silently
        if (n_nodes != 0) begin
          if (n_edges >= EDGES_MAX) g_ovf = 1'b1;
          else begin
            e_tgt[n_edges] = tid;
            e_rel[n_edges] = rel;
            e_wt[n_edges] = wt;
            n_edges++;
            g_ecnt[n_nodes - 1]++;
          end
        end
      end
      spsc_pkg::KIND_CLEAR: begin
        n_nodes = 0;
        n_edges = 0;
        g_ovf = 1'b0;
        hp_cnt = 0;
      end
      default: begin
        searches++;
        predict_path(nid, tid);
      end
    endcase
  endfunction

  // one item: optional random gap, then hold start until the core takes it
  task automatic send(logic [1:0] k, logic [63:0] nid, logic [63:0] tid,
                      logic [31:0] rel, logic [15:0] wt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_node_id <= nid;
    in_target_id <= tid;
    in_relation <= rel;
    in_weight <= wt;
    do @(posedge clk); while (busy);
    items_sent++;
    predict_item(k, nid, tid, rel, wt);
  endtask

  task automatic node(logic [63:0] id);
    send(spsc_pkg::KIND_NODE, id, 64'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic edge_to(logic [63:0] tid, logic [31:0] rel, logic [15:0] wt);
    send(spsc_pkg::KIND_EDGE, {$urandom, $urandom}, tid, rel, wt);
  endtask

  task automatic search(logic [63:0] from_id, logic [63:0] to_id);
    send(spsc_pkg::KIND_SEARCH, from_id, to_id, $urandom, 16'($urandom));
  endtask

  task automatic clear_graph();
    send(spsc_pkg::KIND_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
         16'($urandom));
  endtask

  // drain all expected results, then give the core time to settle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (path_q.size() != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register write, only ever called after settle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      spsc_pkg::CFG_MAX_COST:  lim_cost = val;
      spsc_pkg::CFG_ALLOW_CNT: allow_n = val[2:0];
      spsc_pkg::CFG_REL0:      allow_rel[0] = val;
      spsc_pkg::CFG_REL1:      allow_rel[1] = val;
      spsc_pkg::CFG_REL2:      allow_rel[2] = val;
      default:                 allow_rel[3] = val;
    endcase
  endtask

  // empty graph, dropped edge, start equals goal, unknown ids, extreme ids
  task automatic test_trivial();
    search(64'd5, 64'd5);
    edge_to(64'd1, 32'd1, 16'h0100);
    search(64'd5, 64'd6);
    node(64'd0);
    node('1);
    search(64'd0, 64'd0);
    search('1, '1);
    search(64'd0, 64'd7);
    search(64'd7, '1);
    search(64'd0, '1);
  endtask

  // small fixed graph: skipped weights, unknown target, duplicate ids
  task automatic build_fixed();
    clear_graph();
    node(64'd1);
    edge_to(64'd2, 32'd10, 16'h0100);
    edge_to(64'd3, 32'd11, 16'h7FFF);
    edge_to(64'd2, 32'd12, 16'h0000);
    edge_to(64'd2, 32'd13, 16'h8000);
    edge_to(64'd99, 32'd14, 16'h0001);
    node(64'd2);
    edge_to(64'd3, 32'd20, 16'h0080);
    node(64'd3);
    node(64'd2);
  endtask

  task automatic test_paths();
    build_fixed();
    search(64'd1, 64'd3);
    search(64'd3, 64'd1);
    // goal resolves to the second id 2, which no edge reaches
    search(64'd1, 64'd2);
  endtask

  // whitelist and cost limit, extremes included
  task automatic test_config();
    settle();
    write_reg(spsc_pkg::CFG_ALLOW_CNT, 32'd1);
    write_reg(spsc_pkg::CFG_REL0, 32'd11);
    search(64'd1, 64'd3);
    settle();
    // count above four behaves as four
    write_reg(spsc_pkg::CFG_ALLOW_CNT, 32'd7);
    write_reg(spsc_pkg::CFG_REL1, 32'd10);
    write_reg(spsc_pkg::CFG_REL2, '1);
    write_reg(spsc_pkg::CFG_REL3, 32'd20);
    search(64'd1, 64'd3);
    settle();
    write_reg(spsc_pkg::CFG_MAX_COST, 32'h0000_017F);
    search(64'd1, 64'd3);
    settle();
    write_reg(spsc_pkg::CFG_MAX_COST, 32'h0000_0180);
    search(64'd1, 64'd3);
    settle();
    write_reg(spsc_pkg::CFG_MAX_COST, 32'd0);
    search(64'd1, 64'd3);
    settle();
    write_reg(spsc_pkg::CFG_MAX_COST, spsc_pkg::COST_INF);
    write_reg(spsc_pkg::CFG_ALLOW_CNT, 32'd0);
  endtask

  // repeated improvements fill a heap of twice the node count
  task automatic test_heap_full();
    clear_graph();
    node(64'hA);
    for (int w = 10; w >= 6; w--) edge_to(64'hB, 32'd1, w[15:0]);
    node(64'hB);
    search(64'hA, 64'hB);
  endtask

  // one node too many, then a clear brings the graph back
  task automatic test_load_overflow();
    clear_graph();
    for (int i = 0; i <= NODES_MAX; i++) node(64'(i));
    search(64'd0, 64'd1);
    clear_graph();
    search(64'd0, 64'd1);
    clear_graph();
  endtask

  // random graphs: small id pool so duplicates and hits are common
  task automatic test_random();
    logic [63:0] pool [8];
    logic [31:0] rels [4];
    int nn, ne, round;
    logic [15:0] wt;
    round = 0;
    while (items_sent < 310) begin
      round++;
      idle_pct = (round % 5 == 3) ? 0 : 11;
      foreach (pool[i]) pool[i] = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'(i);
      foreach (rels[i]) rels[i] = ($urandom_range(1) == 0) ? $urandom : i;
      if (round % 3 == 0) begin
        settle();
        case ($urandom_range(2))
          0: write_reg(spsc_pkg::CFG_MAX_COST, spsc_pkg::COST_INF);
          1: write_reg(spsc_pkg::CFG_MAX_COST, $urandom_range(32'h0600, 32'h100));
          default: write_reg(spsc_pkg::CFG_MAX_COST, $urandom);
        endcase
        write_reg(spsc_pkg::CFG_ALLOW_CNT, ($urandom_range(1) == 0) ? 0 : $urandom_range(7));
        for (int i = 0; i < 4; i++)
          write_reg(3'(spsc_pkg::CFG_REL0 + i),
                    ($urandom_range(3) == 0) ? $urandom : rels[$urandom_range(3)]);
      end
      clear_graph();
      nn = $urandom_range(1, 8);
      for (int i = 0; i < nn; i++) begin
        node(pool[$urandom_range(7)]);
        ne = $urandom_range(4);
        for (int j = 0; j < ne; j++) begin
          wt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16'h0400));
          edge_to(($urandom_range(9) == 0) ? {$urandom, $urandom} : pool[$urandom_range(7)],
                  ($urandom_range(9) == 0) ? $urandom : rels[$urandom_range(3)], wt);
        end
      end
      repeat ($urandom_range(2, 6)) search(pool[$urandom_range(7)], pool[$urandom_range(7)]);
      // occasional fully random item
      if ($urandom_range(3) == 0)
        send(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
             16'($urandom));
    end
    idle_pct = 11;
  endtask

  // result checker, compares against the oldest prediction
  always @(posedge clk) begin
    spsc_pkg::res_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (path_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result id=%h status=%0d", $time, out_path_node_id,
                 out_status);
      end else begin
        want = path_q.pop_front();
        if (want.id !== out_path_node_id) begin
          errors++;
          $display("%0t: node id expected %h got %h", $time, want.id, out_path_node_id);
        end
        if (want.rel !== out_path_relation) begin
          errors++;
          $display("%0t: relation expected %h got %h", $time, want.rel, out_path_relation);
        end
        if (want.cost !== out_total_cost) begin
          errors++;
          $display("%0t: cost expected %h got %h", $time, want.cost, out_total_cost);
        end
        if (want.status !== out_status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
        if (want.last !== out_last) begin
          errors++;
          $display("%0t: last expected %0d got %0d", $time, want.last, out_last);
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_trivial();
    test_paths();
    test_config();
    test_heap_full();
    test_load_overflow();
    test_random();
    settle();
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d searches, %0d path results checked", items_sent,
             searches, results_seen);
    $display("cases: empty graph, unknown ids, whitelist, cost limit, heap and load overflow");
    if (errors == 0 && path_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/spsc_pkg.sv
rtl/spsc_ram.sv
rtl/shortest_path_search_core.sv
test/shortest_path_search_core_tb.sv
